// ===== design/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared constants and types for the swept circle box hit test pipeline.
// ----------------------------------------------------------------------------
package sbh_pkg;

  localparam int COORD_WIDTH_DEF        = 24;
  localparam int TIME_FRACTION_BITS_DEF = 16;

  localparam int TOL_W  = 8;
  localparam int NORM_W = 16;

  localparam logic [TOL_W-1:0] NEAR_TOL_RESET = 8'd3;

  // Contact normal codes, signed Q1.14.
  localparam logic [NORM_W-1:0] NORM_ZERO     = 16'h0000;
  localparam logic [NORM_W-1:0] NORM_POS_UNIT = 16'h4000;
  localparam logic [NORM_W-1:0] NORM_NEG_UNIT = 16'hC000;
  localparam logic [NORM_W-1:0] NORM_POS_DIAG = 16'h2D41;
  localparam logic [NORM_W-1:0] NORM_NEG_DIAG = 16'hD2BF;

  // Per-axis flags that ride beside the quotients through the dividers.
  typedef struct packed {
    logic dzero;
    logic in_slab;
    logic sat1;
    logic neg1;
    logic sat2;
    logic neg2;
  } axis_flags_t;

endpackage

// ===== design/sbh_in_if.sv =====
// ----------------------------------------------------------------------------
// sbh_in_if
// Input channel of the hit test: one swept circle and one box per beat.
// ----------------------------------------------------------------------------
interface sbh_in_if #(
  parameter int CW = sbh_pkg::COORD_WIDTH_DEF,
  parameter int F  = sbh_pkg::TIME_FRACTION_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] start_x;
  logic [CW-1:0] start_y;
  logic [CW-1:0] vel_x;
  logic [CW-1:0] vel_y;
  logic [F-1:0]  step_time;
  logic [CW-1:0] box_left;
  logic [CW-1:0] box_top;
  logic [CW-2:0] box_width;
  logic [CW-2:0] box_height;
  logic [CW-2:0] circle_radius;

  modport source (
    output valid, start_x, start_y, vel_x, vel_y, step_time,
           box_left, box_top, box_width, box_height, circle_radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, vel_x, vel_y, step_time,
           box_left, box_top, box_width, box_height, circle_radius,
    output ready
  );
endinterface

// ===== design/sbh_out_if.sv =====
// ----------------------------------------------------------------------------
// sbh_out_if
// Result channel of the hit test: contact normal, entry time and hit flag.
// ----------------------------------------------------------------------------
interface sbh_out_if #(
  parameter int F = sbh_pkg::TIME_FRACTION_BITS_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic [sbh_pkg::NORM_W-1:0] normal_x;
  logic [sbh_pkg::NORM_W-1:0] normal_y;
  logic [F:0]                entry_time;
  logic                      slab_hit;

  modport source (output valid, normal_x, normal_y, entry_time, slab_hit, input ready);
  modport sink   (input valid, normal_x, normal_y, entry_time, slab_hit, output ready);
endinterface

// ===== design/sbh_prep.sv =====
// ----------------------------------------------------------------------------
// sbh_prep
// Two stages: grown box, slab numerators and displacement, then magnitudes,
// signs and saturation flags for the dividers.
// ----------------------------------------------------------------------------
module sbh_prep #(
  parameter int CW = sbh_pkg::COORD_WIDTH_DEF,
  parameter int F  = sbh_pkg::TIME_FRACTION_BITS_DEF,
  localparam int XW = CW + 3,
  localparam int DW = CW + F,
  localparam int NW = XW + 2 * F
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [CW-1:0]          start_x,
  input  logic [CW-1:0]          start_y,
  input  logic [CW-1:0]          vel_x,
  input  logic [CW-1:0]          vel_y,
  input  logic [F-1:0]           step_time,
  input  logic [CW-1:0]          box_left,
  input  logic [CW-1:0]          box_top,
  input  logic [CW-2:0]          box_width,
  input  logic [CW-2:0]          box_height,
  input  logic [CW-2:0]          circle_radius,
  output logic [1:0][CW-1:0]     s_o,
  output logic [1:0][CW-1:0]     v_o,
  output logic [1:0][CW+1:0]     lo_o,
  output logic [1:0][CW+1:0]     hi_o,
  output logic [F-1:0]           dt_o,
  output logic [1:0][NW-1:0]     n1_o,
  output logic [1:0][NW-1:0]     n2_o,
  output logic [1:0][DW-1:0]     den_o,
  output sbh_pkg::axis_flags_t   fl_o [2]
);

  logic [1:0][CW-1:0] s_in, v_in, b_in;
  logic [1:0][CW-2:0] sz_in;
  logic [1:0][CW+1:0] lo_nxt, hi_nxt;
  logic [1:0][XW-1:0] n1_nxt, n2_nxt;
  logic signed [CW+F:0] d_nxt [2];

  logic [1:0][CW-1:0] s_a_r, v_a_r;
  logic [1:0][CW+1:0] lo_a_r, hi_a_r;
  logic [1:0][XW-1:0] n1_a_r, n2_a_r;
  logic signed [CW+F:0] d_a_r [2];
  logic [F-1:0]       dt_a_r;

  logic [1:0][XW-1:0] un1, un2;
  logic [1:0][NW-1:0] n1_nxt_b, n2_nxt_b;
  logic [1:0][DW-1:0] den_nxt;
  logic [CW+F:0]      ud_full [2];
  sbh_pkg::axis_flags_t fl_nxt [2];

  logic [1:0][CW-1:0]   s_b_r, v_b_r;
  logic [1:0][CW+1:0]   lo_b_r, hi_b_r;
  logic [F-1:0]         dt_b_r;
  logic [1:0][NW-1:0]   n1_b_r, n2_b_r;
  logic [1:0][DW-1:0]   den_b_r;
  sbh_pkg::axis_flags_t fl_b_r [2];

  assign s_in  = {start_y, start_x};
  assign v_in  = {vel_y, vel_x};
  assign b_in  = {box_top, box_left};
  assign sz_in = {box_height, box_width};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      lo_nxt[a] = {{2{b_in[a][CW-1]}}, b_in[a]} - {3'b000, circle_radius};
      hi_nxt[a] = lo_nxt[a] + {3'b000, sz_in[a]} + {2'b00, circle_radius, 1'b0};
      n1_nxt[a] = {lo_nxt[a][CW+1], lo_nxt[a]} - {{3{s_in[a][CW-1]}}, s_in[a]};
      n2_nxt[a] = {hi_nxt[a][CW+1], hi_nxt[a]} - {{3{s_in[a][CW-1]}}, s_in[a]};
      d_nxt[a]  = $signed(v_in[a]) * $signed({1'b0, step_time});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_a_r  <= s_in;
      v_a_r  <= v_in;
      lo_a_r <= lo_nxt;
      hi_a_r <= hi_nxt;
      n1_a_r <= n1_nxt;
      n2_a_r <= n2_nxt;
      d_a_r  <= d_nxt;
      dt_a_r <= step_time;
    end
  end

  // Magnitudes for the unsigned dividers; the quotient sign is kept aside.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      un1[a] = n1_a_r[a][XW-1] ? (XW'(0) - n1_a_r[a]) : n1_a_r[a];
      un2[a] = n2_a_r[a][XW-1] ? (XW'(0) - n2_a_r[a]) : n2_a_r[a];
      ud_full[a] = d_a_r[a][CW+F] ? ((CW+F+1)'(0) - d_a_r[a]) : d_a_r[a];
      den_nxt[a] = ud_full[a][DW-1:0];
      n1_nxt_b[a] = {un1[a], {(2*F){1'b0}}};
      n2_nxt_b[a] = {un2[a], {(2*F){1'b0}}};
      fl_nxt[a].dzero  = (d_a_r[a] == '0);
      fl_nxt[a].in_slab = !(($signed({{2{s_a_r[a][CW-1]}}, s_a_r[a]}) < $signed(lo_a_r[a])) ||
                            ($signed({{2{s_a_r[a][CW-1]}}, s_a_r[a]}) > $signed(hi_a_r[a])));
      fl_nxt[a].sat1 = ({un1[a], {F{1'b0}}} >= {den_nxt[a], 1'b0});
      fl_nxt[a].sat2 = ({un2[a], {F{1'b0}}} >= {den_nxt[a], 1'b0});
      fl_nxt[a].neg1 = n1_a_r[a][XW-1] ^ d_a_r[a][CW+F];
      fl_nxt[a].neg2 = n2_a_r[a][XW-1] ^ d_a_r[a][CW+F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_b_r   <= s_a_r;
      v_b_r   <= v_a_r;
      lo_b_r  <= lo_a_r;
      hi_b_r  <= hi_a_r;
      dt_b_r  <= dt_a_r;
      n1_b_r  <= n1_nxt_b;
      n2_b_r  <= n2_nxt_b;
      den_b_r <= den_nxt;
      fl_b_r  <= fl_nxt;
    end
  end

  assign s_o   = s_b_r;
  assign v_o   = v_b_r;
  assign lo_o  = lo_b_r;
  assign hi_o  = hi_b_r;
  assign dt_o  = dt_b_r;
  assign n1_o  = n1_b_r;
  assign n2_o  = n2_b_r;
  assign den_o = den_b_r;
  assign fl_o  = fl_b_r;

endmodule

// ===== design/sbh_div.sv =====
// ----------------------------------------------------------------------------
// sbh_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sbh_div #(
  parameter int NW = 59,
  parameter int DW = 40,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in, shd, diff;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign shd  = NW'(den_in) << (QW - 1 - k);
    assign take = (rem_in >= shd);
    assign diff = rem_in - shd;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff : rem_in;
        den_r[k] <= den_in;
        q_r[k]   <= q_in | (QW'(take) << (QW - 1 - k));
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== design/sbh_post.sv =====
// ----------------------------------------------------------------------------
// sbh_post
// Slab interval merge, hit point and near-edge normal, four register stages.
// ----------------------------------------------------------------------------
module sbh_post #(
  parameter int CW = sbh_pkg::COORD_WIDTH_DEF,
  parameter int F  = sbh_pkg::TIME_FRACTION_BITS_DEF,
  localparam int QW = F + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sbh_pkg::TOL_W-1:0]   tol,
  input  logic [1:0][QW-1:0]          q1_i,
  input  logic [1:0][QW-1:0]          q2_i,
  input  sbh_pkg::axis_flags_t        fl_i [2],
  input  logic [1:0][CW-1:0]          s_i,
  input  logic [1:0][CW-1:0]          v_i,
  input  logic [1:0][CW+1:0]          lo_i,
  input  logic [1:0][CW+1:0]          hi_i,
  input  logic [F-1:0]                dt_i,
  output logic [sbh_pkg::NORM_W-1:0]  normal_x_o,
  output logic [sbh_pkg::NORM_W-1:0]  normal_y_o,
  output logic [F:0]                  entry_time_o,
  output logic                        slab_hit_o
);

  localparam int TW = F + 3;
  localparam int EW = CW + 3;
  localparam logic signed [TW-1:0] TONE = TW'(1) << F;
  localparam logic signed [TW-1:0] TSAT = TW'(1) << (F + 1);

  logic signed [TW-1:0] t1 [2], t2 [2], tlo [2], thi [2];
  logic signed [TW-1:0] tin0, tout0, tin1, tout1;
  logic ok0, ok1;

  logic               hit_c_r, hit_d_r, hit_e_r;
  logic [F:0]         tin_c_r, tin_d_r, tin_e_r;
  logic [1:0][CW-1:0] s_c_r, s_d_r, s_e_r, v_c_r, v_d_r;
  logic [1:0][CW+1:0] lo_c_r, lo_d_r, lo_e_r, hi_c_r, hi_d_r, hi_e_r;
  logic [F-1:0]       dt_c_r;
  logic [2*F:0]       prod_d;
  logic [F-1:0]       eff_d_r;
  logic signed [CW+F:0] pv_nxt [2];
  logic signed [CW+F:0] pv_e_r [2];

  logic [1:0][CW+1:0] hp;
  logic [1:0][EW-1:0] dl, dh;
  logic [EW-1:0]      tolx;
  logic [1:0]         near_lo, near_hi;
  logic [sbh_pkg::NORM_W-1:0] nx_nxt, ny_nxt;

  logic [sbh_pkg::NORM_W-1:0] nx_r, ny_r;
  logic [F:0]                 et_r;
  logic                       hit_r;

  // Stage C: signed slab times, ordered, then the running entry and exit.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      t1[a] = fl_i[a].sat1 ? TSAT : $signed({2'b00, q1_i[a]});
      t2[a] = fl_i[a].sat2 ? TSAT : $signed({2'b00, q2_i[a]});
      if (fl_i[a].neg1) t1[a] = -t1[a];
      if (fl_i[a].neg2) t2[a] = -t2[a];
      tlo[a] = (t1[a] > t2[a]) ? t2[a] : t1[a];
      thi[a] = (t1[a] > t2[a]) ? t1[a] : t2[a];
    end
    if (fl_i[0].dzero) begin
      tin0  = '0;
      tout0 = TONE;
      ok0   = fl_i[0].in_slab;
    end else begin
      tin0  = (tlo[0] > 0) ? tlo[0] : '0;
      tout0 = (thi[0] < TONE) ? thi[0] : TONE;
      ok0   = !((tin0 > tout0) || (tout0 < 0) || (tin0 > TONE));
    end
    if (fl_i[1].dzero) begin
      tin1  = tin0;
      tout1 = tout0;
      ok1   = fl_i[1].in_slab;
    end else begin
      tin1  = (tlo[1] > tin0) ? tlo[1] : tin0;
      tout1 = (thi[1] < tout0) ? thi[1] : tout0;
      ok1   = !((tin1 > tout1) || (tout1 < 0) || (tin1 > TONE));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_c_r <= ok0 && ok1;
      tin_c_r <= tin1[F:0];
      s_c_r   <= s_i;
      v_c_r   <= v_i;
      lo_c_r  <= lo_i;
      hi_c_r  <= hi_i;
      dt_c_r  <= dt_i;
    end
  end

  // Stage D: effective time step up to the entry point.
  assign prod_d = dt_c_r * tin_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      eff_d_r <= prod_d[2*F-1:F];
      hit_d_r <= hit_c_r;
      tin_d_r <= tin_c_r;
      s_d_r   <= s_c_r;
      v_d_r   <= v_c_r;
      lo_d_r  <= lo_c_r;
      hi_d_r  <= hi_c_r;
    end
  end

  // Stage E: displacement to the hit point on both axes.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      pv_nxt[a] = $signed(v_d_r[a]) * $signed({1'b0, eff_d_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv_e_r  <= pv_nxt;
      hit_e_r <= hit_d_r;
      tin_e_r <= tin_d_r;
      s_e_r   <= s_d_r;
      lo_e_r  <= lo_d_r;
      hi_e_r  <= hi_d_r;
    end
  end

  // Stage F: hit point, edge closeness and the normal code.
  assign tolx = EW'(tol);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      hp[a] = {{2{s_e_r[a][CW-1]}}, s_e_r[a]} + {pv_e_r[a][CW+F], pv_e_r[a][CW+F:F]};
      dl[a] = {hp[a][CW+1], hp[a]} - {lo_e_r[a][CW+1], lo_e_r[a]};
      dh[a] = {hp[a][CW+1], hp[a]} - {hi_e_r[a][CW+1], hi_e_r[a]};
      near_lo[a] = ($signed(dl[a]) < $signed(tolx)) && ($signed(dl[a]) > -$signed(tolx));
      near_hi[a] = ($signed(dh[a]) < $signed(tolx)) && ($signed(dh[a]) > -$signed(tolx));
    end
    nx_nxt = sbh_pkg::NORM_ZERO;
    ny_nxt = sbh_pkg::NORM_ZERO;
    if ((near_lo[0] || near_hi[0]) && (near_lo[1] || near_hi[1])) begin
      nx_nxt = near_hi[0] ? sbh_pkg::NORM_POS_DIAG : sbh_pkg::NORM_NEG_DIAG;
      ny_nxt = near_hi[1] ? sbh_pkg::NORM_POS_DIAG : sbh_pkg::NORM_NEG_DIAG;
    end else if (near_lo[0]) begin
      nx_nxt = sbh_pkg::NORM_NEG_UNIT;
    end else if (near_hi[0]) begin
      nx_nxt = sbh_pkg::NORM_POS_UNIT;
    end else if (near_lo[1]) begin
      ny_nxt = sbh_pkg::NORM_NEG_UNIT;
    end else if (near_hi[1]) begin
      ny_nxt = sbh_pkg::NORM_POS_UNIT;
    end
    if (!hit_e_r) begin
      nx_nxt = sbh_pkg::NORM_ZERO;
      ny_nxt = sbh_pkg::NORM_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      et_r  <= hit_e_r ? tin_e_r : '0;
      hit_r <= hit_e_r;
    end
  end

  assign normal_x_o   = nx_r;
  assign normal_y_o   = ny_r;
  assign entry_time_o = et_r;
  assign slab_hit_o   = hit_r;

endmodule

// ===== design/swept_circle_box_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// swept_circle_box_hit_test_top
// Swept circle against axis-aligned box: slab test, entry time and normal.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on in_bus carries one moving circle (start, velocity,
// radius, time step) and one box. Each beat yields exactly one result beat
// on out_bus with the contact normal, the entry time and the hit flag.
// Both channels use valid/ready; a beat moves when both are high.
// The pipeline is TIME_FRACTION_BITS + 7 register stages deep: two
// preparation stages, one stage per quotient bit in the four parallel
// slab dividers, and four stages for interval merge, effective time, hit
// point and normal selection.
// Throughput is one beat per cycle while the receiver does not stall; the
// per-bit divider stages set the latency, and every stage is fully pipelined.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_bus.ready drops, so nothing is lost or repeated; bubbles in the
// pipeline still advance while the last stage is empty.
// Reset (rst_n low at a clock edge) empties the pipeline and sets
// near_tolerance to 3. cfg_we writes near_tolerance from cfg_wdata and
// should only be used while the block is idle.
// ----------------------------------------------------------------------------
module swept_circle_box_hit_test_top #(
  parameter int COORD_WIDTH        = sbh_pkg::COORD_WIDTH_DEF,
  parameter int TIME_FRACTION_BITS = sbh_pkg::TIME_FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sbh_in_if.sink                    in_bus,
  sbh_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [sbh_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = TIME_FRACTION_BITS;
  localparam int XW  = CW + 3;
  localparam int DW  = CW + F;
  localparam int NW  = XW + 2 * F;
  localparam int QW  = F + 1;
  localparam int LAT = QW + 6;

  // Global advance: the pipeline moves unless a result sits unclaimed.
  logic en;
  logic [LAT-1:0] vld_r;
  logic [sbh_pkg::TOL_W-1:0] tol_r;

  assign en           = !vld_r[LAT-1] || out_bus.ready;
  assign in_bus.ready = en;
  assign out_bus.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_bus.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= sbh_pkg::NEAR_TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Preparation stages.
  logic [1:0][CW-1:0]   s_p, v_p;
  logic [1:0][CW+1:0]   lo_p, hi_p;
  logic [F-1:0]         dt_p;
  logic [1:0][NW-1:0]   n1_p, n2_p;
  logic [1:0][DW-1:0]   den_p;
  sbh_pkg::axis_flags_t fl_p [2];

  sbh_prep #(.CW(CW), .F(F)) u_prep (
    .clk           (clk),
    .en            (en),
    .start_x       (in_bus.start_x),
    .start_y       (in_bus.start_y),
    .vel_x         (in_bus.vel_x),
    .vel_y         (in_bus.vel_y),
    .step_time     (in_bus.step_time),
    .box_left      (in_bus.box_left),
    .box_top       (in_bus.box_top),
    .box_width     (in_bus.box_width),
    .box_height    (in_bus.box_height),
    .circle_radius (in_bus.circle_radius),
    .s_o           (s_p),
    .v_o           (v_p),
    .lo_o          (lo_p),
    .hi_o          (hi_p),
    .dt_o          (dt_p),
    .n1_o          (n1_p),
    .n2_o          (n2_p),
    .den_o         (den_p),
    .fl_o          (fl_p)
  );

  // Four slab dividers: low and high edge on each axis.
  logic [1:0][QW-1:0] q1, q2;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    sbh_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_lo (
      .clk (clk),
      .en  (en),
      .num (n1_p[a]),
      .den (den_p[a]),
      .quo (q1[a])
    );
    sbh_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_hi (
      .clk (clk),
      .en  (en),
      .num (n2_p[a]),
      .den (den_p[a]),
      .quo (q2[a])
    );
  end

  // Side data follows the quotients through a matching delay line.
  logic [1:0][CW-1:0]   s_dl_r  [QW];
  logic [1:0][CW-1:0]   v_dl_r  [QW];
  logic [1:0][CW+1:0]   lo_dl_r [QW];
  logic [1:0][CW+1:0]   hi_dl_r [QW];
  logic [F-1:0]         dt_dl_r [QW];
  sbh_pkg::axis_flags_t fl_dl_r [QW][2];

  always_ff @(posedge clk) begin
    if (en) begin
      s_dl_r[0]  <= s_p;
      v_dl_r[0]  <= v_p;
      lo_dl_r[0] <= lo_p;
      hi_dl_r[0] <= hi_p;
      dt_dl_r[0] <= dt_p;
      fl_dl_r[0] <= fl_p;
      for (int k = 1; k < QW; k++) begin
        s_dl_r[k]  <= s_dl_r[k-1];
        v_dl_r[k]  <= v_dl_r[k-1];
        lo_dl_r[k] <= lo_dl_r[k-1];
        hi_dl_r[k] <= hi_dl_r[k-1];
        dt_dl_r[k] <= dt_dl_r[k-1];
        fl_dl_r[k] <= fl_dl_r[k-1];
      end
    end
  end

  // Merge, hit point and normal; the last stage is the output register.
  sbh_post #(.CW(CW), .F(F)) u_post (
    .clk          (clk),
    .en           (en),
    .tol          (tol_r),
    .q1_i         (q1),
    .q2_i         (q2),
    .fl_i         (fl_dl_r[QW-1]),
    .s_i          (s_dl_r[QW-1]),
    .v_i          (v_dl_r[QW-1]),
    .lo_i         (lo_dl_r[QW-1]),
    .hi_i         (hi_dl_r[QW-1]),
    .dt_i         (dt_dl_r[QW-1]),
    .normal_x_o   (out_bus.normal_x),
    .normal_y_o   (out_bus.normal_y),
    .entry_time_o (out_bus.entry_time),
    .slab_hit_o   (out_bus.slab_hit)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the swept circle box hit test: an in-bench predictor works out the
// normal, entry time and hit flag for each beat, and every result beat is
// compared in order against it under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW = sbh_pkg::COORD_WIDTH_DEF;
  localparam int F  = sbh_pkg::TIME_FRACTION_BITS_DEF;
  localparam int LATENCY = F + 7;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [CW-1:0] sx, sy, vx, vy;
    logic [F-1:0]  dt;
    logic [CW-1:0] bl, bt;
    logic [CW-2:0] bw, bh, rad;
  } sweep_t;

  typedef struct packed {
    logic [sbh_pkg::NORM_W-1:0] nx, ny;
    logic [F:0]                 tentry;
    logic                       hit;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [sbh_pkg::TOL_W-1:0] cfg_wdata = '0;

  sbh_in_if  #(.CW(CW), .F(F)) in_bus ();
  sbh_out_if #(.F(F))          out_bus ();

  swept_circle_box_hit_test_top #(.COORD_WIDTH(CW), .TIME_FRACTION_BITS(F)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state: the tolerance register as the block should hold it.
  logic [sbh_pkg::TOL_W-1:0] tol_shadow = sbh_pkg::NEAR_TOL_RESET;
  contact_t expected_contacts[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit in_flight_hold = 1'b0;

  // Slab time in Q2.F, magnitude truncated and saturated at 2.0, then signed.
  function automatic longint slab_time(longint num, longint den);
    longint un, ud, mag;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if ((un << F) >= 2 * ud) mag = 2 * (longint'(1) << F);
    else mag = (un << (2 * F)) / ud;
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic longint ldiff(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic contact_t predict_contact(sweep_t s);
    contact_t c;
    longint p[2], v[2], lo[2], hi[2], hp[2];
    longint dt, r, tin, tout, d, t1, t2, x, eff;
    bit hit, nl, nr, nt, nb;
    dt = s.dt;
    r = s.rad;
    p[0] = longint'(signed'(s.sx));
    p[1] = longint'(signed'(s.sy));
    v[0] = longint'(signed'(s.vx));
    v[1] = longint'(signed'(s.vy));
    lo[0] = longint'(signed'(s.bl)) - r;
    lo[1] = longint'(signed'(s.bt)) - r;
    hi[0] = lo[0] + longint'(s.bw) + 2 * r;
    hi[1] = lo[1] + longint'(s.bh) + 2 * r;
    tin = 0;
    tout = longint'(1) << F;
    hit = 1'b1;
    c = '0;
    for (int a = 0; a < 2; a++) begin
      if (hit) begin
        d = v[a] * dt;
        if (d == 0) begin
          if (p[a] < lo[a] || p[a] > hi[a]) hit = 1'b0;
        end else begin
          t1 = slab_time(lo[a] - p[a], d);
          t2 = slab_time(hi[a] - p[a], d);
          if (t1 > t2) begin
            x = t1; t1 = t2; t2 = x;
          end
          if (t1 > tin) tin = t1;
          if (t2 < tout) tout = t2;
          if (tin > tout || tout < 0 || tin > (longint'(1) << F)) hit = 1'b0;
        end
      end
    end
    if (!hit) return c;
    // Arithmetic shifts on longint floor toward minus infinity, as needed.
    eff = (dt * tin) >>> F;
    for (int a = 0; a < 2; a++) hp[a] = p[a] + ((v[a] * eff) >>> F);
    nl = ldiff(hp[0], lo[0]) < tol_shadow;
    nr = ldiff(hp[0], hi[0]) < tol_shadow;
    nt = ldiff(hp[1], lo[1]) < tol_shadow;
    nb = ldiff(hp[1], hi[1]) < tol_shadow;
    c.nx = sbh_pkg::NORM_ZERO;
    c.ny = sbh_pkg::NORM_ZERO;
    if ((nl || nr) && (nt || nb)) begin
      c.nx = nr ? sbh_pkg::NORM_POS_DIAG : sbh_pkg::NORM_NEG_DIAG;
      c.ny = nb ? sbh_pkg::NORM_POS_DIAG : sbh_pkg::NORM_NEG_DIAG;
    end else if (nl) c.nx = sbh_pkg::NORM_NEG_UNIT;
    else if (nr) c.nx = sbh_pkg::NORM_POS_UNIT;
    else if (nt) c.ny = sbh_pkg::NORM_NEG_UNIT;
    else if (nb) c.ny = sbh_pkg::NORM_POS_UNIT;
    c.tentry = tin[F:0];
    c.hit = 1'b1;
    return c;
  endfunction

  // Drives one beat after a random gap and waits until it is accepted.
  // Valid stays high after acceptance so that back-to-back beats need no
  // second assignment in the same time step; idle gaps drop it.
  task automatic send_sweep(sweep_t s);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    {in_bus.start_x, in_bus.start_y, in_bus.vel_x, in_bus.vel_y, in_bus.step_time,
     in_bus.box_left, in_bus.box_top, in_bus.box_width, in_bus.box_height,
     in_bus.circle_radius} <= s;
    expected_contacts.push_back(predict_contact(s));
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Pause until every expected result is back and the pipe has drained.
  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [sbh_pkg::TOL_W-1:0] val);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_shadow = val;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return CW'($urandom);
      1: return CW'(signed'($urandom_range(0, 8000)) - 4000);
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return {1'b1, {(CW-1){1'b0}}};
      default: return CW'(signed'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // Mostly circles aimed at a box nearby, so hits, edges and corners occur.
  function automatic sweep_t rand_sweep();
    sweep_t s;
    int tx, ty;
    s.dt = ($urandom_range(0, 9) == 0) ? F'($urandom) :
           F'($urandom_range(16'h4000, 16'hffff));
    if ($urandom_range(0, 9) < 2) begin
      s = sweep_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom});
      s.sx = rand_coord(); s.vy = rand_coord();
      return s;
    end
    s.bl = CW'(signed'($urandom_range(0, 20000)) - 10000);
    s.bt = CW'(signed'($urandom_range(0, 20000)) - 10000);
    s.bw = (CW-1)'($urandom_range(0, 3000));
    s.bh = (CW-1)'($urandom_range(0, 3000));
    s.rad = (CW-1)'($urandom_range(0, 600));
    s.sx = CW'(signed'(s.bl) + signed'($urandom_range(0, 20000)) - 10000);
    s.sy = CW'(signed'(s.bt) + signed'($urandom_range(0, 20000)) - 10000);
    tx = signed'(s.bl) + int'($urandom_range(0, 3000)) - signed'(s.sx);
    ty = signed'(s.bt) + int'($urandom_range(0, 3000)) - signed'(s.sy);
    if ($urandom_range(0, 2) == 0) begin
      // Aim exactly at a grown-box corner.
      tx = signed'(s.bl) - int'(s.rad) - signed'(s.sx);
      ty = signed'(s.bt) - int'(s.rad) - signed'(s.sy);
    end
    s.vx = ($urandom_range(0, 7) == 0) ? '0 : CW'(tx + tx / 3);
    s.vy = ($urandom_range(0, 7) == 0) ? '0 : CW'(ty + ty / 3);
    return s;
  endfunction

  // Directed beats: field extremes, starts inside, resting axes, corners.
  task automatic test_directed();
    sweep_t s;
    s = '0; send_sweep(s);                          // everything zero: hit at 0
    s = '1; send_sweep(s);
    s = '0; s.sx = {1'b1, {(CW-1){1'b0}}}; s.vx = {1'b0, {(CW-1){1'b1}}};
    s.dt = '1; s.bw = '1; s.bh = '1; s.rad = '1; send_sweep(s);
    s = '0; s.sx = 24'hffff00; s.vx = 24'h000200; s.dt = 16'hffff;
    s.bw = 23'h100; s.bh = 23'h100; send_sweep(s);  // left face
    s.sx = 24'h000400; s.vx = 24'hfffe00; send_sweep(s);  // right face
    s = '0; s.sy = 24'hffff00; s.vy = 24'h000200; s.dt = 16'hffff;
    s.bw = 23'h100; s.bh = 23'h100; send_sweep(s);  // top face
    s.sy = 24'h000400; s.vy = 24'hfffe00; send_sweep(s);  // bottom face
    s.sx = 24'h000400; s.vx = 24'hfffe00; send_sweep(s);  // bottom-right corner
    s.sx = 24'hffff00; s.vx = 24'h000200; s.sy = 24'hffff00; s.vy = 24'h000200;
    send_sweep(s);                                  // top-left corner
    s = '0; s.sx = 24'h000080; s.sy = 24'h000080; s.bw = 23'h100; s.bh = 23'h100;
    s.vx = 24'h000100; s.dt = 16'h8000; send_sweep(s);  // starts inside
    s.vx = '0; s.vy = '0; s.sx = 24'h000500; send_sweep(s);  // resting, outside
    s.dt = '0; s.vx = 24'h7fffff; s.sx = 24'h000080; send_sweep(s);  // zero step
    s = '0; s.bw = '0; s.bh = '0; s.sx = 24'hfffff0; s.vx = 24'h000100; s.dt = 16'h1000;
    send_sweep(s);                                  // zero-size box, reached at the end of the step
    s.vx = 24'h800000; s.sx = 24'h7fffff; s.dt = 16'hffff; send_sweep(s);
    s.rad = 23'h000020; s.sx = 24'h000100; s.vx = 24'hffff00; send_sweep(s);
  endtask

  task automatic test_random(int count);
    repeat (count) send_sweep(rand_sweep());
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(60);
      begin
        repeat (LATENCY * 4) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver: random stalls per beat, long hold-off on request.
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0 || hold_off) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    contact_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = expected_contacts.pop_front();
        if (want.nx !== out_bus.normal_x || want.ny !== out_bus.normal_y ||
            want.tentry !== out_bus.entry_time || want.hit !== out_bus.slab_hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp nx=%h ny=%h t=%h hit=%b got nx=%h ny=%h t=%h hit=%b",
                     want.nx, want.ny, want.tentry, want.hit, out_bus.normal_x,
                     out_bus.normal_y, out_bus.entry_time, out_bus.slab_hit);
        end
      end
    end
  end

  // Watchdog over cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_bus.valid <= 1'b0;
    {in_bus.start_x, in_bus.start_y, in_bus.vel_x, in_bus.vel_y, in_bus.step_time,
     in_bus.box_left, in_bus.box_top, in_bus.box_width, in_bus.box_height,
     in_bus.circle_radius} <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(300);
    write_tolerance(8'd0);
    test_directed();
    test_random(250);
    write_tolerance(8'd255);
    test_directed();
    test_random(250);
    write_tolerance(8'd40);
    test_random(250);
    write_tolerance(8'd1);
    test_random(295);
    drain_pipe();
    if (mismatches == 0 && expected_contacts.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
